### hdl/cpra_pkg.sv
package cpra_pkg;

   localparam int COUNT_W = 10;
   localparam int PAGE_W = 10;
   localparam int STATUS_W = 2;

   localparam logic [PAGE_W-1:0] SEARCH_BASE_RESET = PAGE_W'(284);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_NOSPACE = 2'd2
   } status_type;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       clear;
      logic       scan_init;
      logic       scan;
      logic       mark_init;
      logic       free_init;
      logic       write;
      logic       wdata;
      logic       res_load;
      status_type res_status;
      logic       res_zero_start;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_free;
      logic alloc_bad;
      logic free_bad;
      logic count_zero;
      logic found;
      logic exhausted;
      logic at_end;
      logic clear_done;
   } sts_type;

endpackage

### hdl/cpra_req_if.sv
interface cpra_req_if;
   import cpra_pkg::*;

   logic               valid;
   logic               ready;
   logic               op;
   logic [COUNT_W-1:0] page_count;
   logic [PAGE_W-1:0]  page_start;

   modport source (output valid, op, page_count, page_start, input ready);
   modport sink (input valid, op, page_count, page_start, output ready);
endinterface

### hdl/cpra_rsp_if.sv
interface cpra_rsp_if;
   import cpra_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [PAGE_W-1:0]   start_page;

   modport source (output valid, status, start_page, input ready);
   modport sink (input valid, status, start_page, output ready);
endinterface

### hdl/contiguous_page_run_allocator.sv
// First-fit contiguous page allocator over a one-bit-per-page used bitmap held in a
// single RAM. After reset a clearing pass marks every page free; no request word is
// taken until it ends (csr writes are taken at any time). Requests are handled one
// at a time, one bitmap bit per cycle through the RAM port: an allocate is decoded,
// then scans from search_base to the end of the first fitting run through the
// registered read, then writes each page of the run to mark it, then presents the
// response. A free is decoded, then writes each page of its run clear, then
// presents the response. Rejected requests answer right after decode. One response
// word is returned per request.
module contiguous_page_run_allocator #(
   parameter int TOTAL_PAGE_COUNT = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   cpra_req_if.sink                    req,
   cpra_rsp_if.source                  rsp,
   input  logic                        csr_we,
   input  logic [cpra_pkg::PAGE_W-1:0] csr_wdata
);
   import cpra_pkg::*;

   cmd_type cmd;
   sts_type sts;

   cpra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cpra_dp #(
      .TOTAL_PAGE_COUNT (TOTAL_PAGE_COUNT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_op         (req.op),
      .req_page_count (req.page_count),
      .req_page_start (req.page_start),
      .rsp_status     (rsp.status),
      .rsp_start_page (rsp.start_page),
      .cmd            (cmd),
      .sts            (sts)
   );
endmodule

### hdl/cpra_ram.sv
module cpra_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

### hdl/cpra_ctrl.sv
module cpra_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  cpra_pkg::sts_type sts,
   output cpra_pkg::cmd_type cmd
);
   import cpra_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_MARK,
      ST_FREE,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.res_status = STATUS_OK;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.is_free) begin
               priority if (sts.free_bad) begin
                  cmd.res_load = 1'b1;
                  cmd.res_status = STATUS_INVALID;
                  cmd.res_zero_start = 1'b1;
                  state_in = ST_RESP;
               end else if (sts.count_zero) begin
                  cmd.res_load = 1'b1;
                  cmd.res_status = STATUS_OK;
                  cmd.res_zero_start = 1'b1;
                  state_in = ST_RESP;
               end else begin
                  cmd.free_init = 1'b1;
                  state_in = ST_FREE;
               end
            end else if (sts.alloc_bad) begin
               cmd.res_load = 1'b1;
               cmd.res_status = STATUS_INVALID;
               cmd.res_zero_start = 1'b1;
               state_in = ST_RESP;
            end else begin
               cmd.scan_init = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.found) begin
               cmd.mark_init = 1'b1;
               state_in = ST_MARK;
            end else if (sts.exhausted) begin
               cmd.res_load = 1'b1;
               cmd.res_status = STATUS_NOSPACE;
               cmd.res_zero_start = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_MARK: begin
            cmd.write = 1'b1;
            cmd.wdata = 1'b1;
            if (sts.at_end) begin
               cmd.res_load = 1'b1;
               cmd.res_status = STATUS_OK;
               state_in = ST_RESP;
            end
         end
         ST_FREE: begin
            cmd.write = 1'b1;
            cmd.wdata = 1'b0;
            if (sts.at_end) begin
               cmd.res_load = 1'b1;
               cmd.res_status = STATUS_OK;
               cmd.res_zero_start = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

### hdl/cpra_dp.sv
module cpra_dp #(
   parameter int TOTAL_PAGE_COUNT = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [cpra_pkg::PAGE_W-1:0]     csr_wdata,
   input  logic                            req_op,
   input  logic [cpra_pkg::COUNT_W-1:0]    req_page_count,
   input  logic [cpra_pkg::PAGE_W-1:0]     req_page_start,
   output logic [cpra_pkg::STATUS_W-1:0]   rsp_status,
   output logic [cpra_pkg::PAGE_W-1:0]     rsp_start_page,
   input  cpra_pkg::cmd_type               cmd,
   output cpra_pkg::sts_type               sts
);
   import cpra_pkg::*;

   localparam int PW = $clog2(TOTAL_PAGE_COUNT);
   localparam int CW = $clog2(TOTAL_PAGE_COUNT + 1);
   localparam int XW = ((CW > PAGE_W) ? CW : PAGE_W) + 1;
   localparam logic [XW-1:0] TOTAL_X = XW'(TOTAL_PAGE_COUNT);
   localparam logic [CW-1:0] TOTAL_C = CW'(TOTAL_PAGE_COUNT);
   localparam logic [CW-1:0] LAST_C = CW'(TOTAL_PAGE_COUNT - 1);

   logic [PAGE_W-1:0]  base_ff, base_in;
   logic               op_ff, op_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [PAGE_W-1:0]  pstart_ff, pstart_in;
   logic [CW-1:0]      ctr_ff, ctr_in;
   logic [PW-1:0]      end_ff, end_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [PW-1:0]      rd_addr_ff, rd_addr_in;
   logic [CW-1:0]      run_ff, run_in;
   status_type         res_status_ff, res_status_in;
   logic [PAGE_W-1:0]  res_start_ff, res_start_in;

   logic          ram_we;
   logic          ram_wdata;
   logic          ram_rdata;
   logic [XW-1:0] base_x, count_x, pstart_x, run_next, first_x, free_end_x;

   cpra_ram #(
      .WIDTH (1),
      .DEPTH (TOTAL_PAGE_COUNT)
   ) u_bitmap (
      .clock (clock),
      .we    (ram_we),
      .waddr (ctr_ff[PW-1:0]),
      .wdata (ram_wdata),
      .raddr (ctr_ff[PW-1:0]),
      .rdata (ram_rdata)
   );

   assign base_x = XW'(base_ff);
   assign count_x = XW'(count_ff);
   assign pstart_x = XW'(pstart_ff);
   assign run_next = XW'(run_ff) + XW'(1);
   // run ends at the page just read
   assign first_x = XW'(rd_addr_ff) + XW'(1) - count_x;
   assign free_end_x = pstart_x + count_x - XW'(1);

   always_comb begin
      sts.is_free = (op_ff == OP_FREE);
      sts.count_zero = (count_ff == '0);
      sts.alloc_bad = (count_ff == '0) || (base_x >= TOTAL_X) || (count_x > TOTAL_X - base_x);
      sts.free_bad = (pstart_x + count_x > TOTAL_X);
      sts.found = rd_valid_ff && !ram_rdata && (run_next == count_x);
      sts.exhausted = !rd_valid_ff && (ctr_ff == TOTAL_C);
      sts.at_end = (ctr_ff[PW-1:0] == end_ff);
      sts.clear_done = (ctr_ff == LAST_C);
   end

   assign rsp_status = res_status_ff;
   assign rsp_start_page = res_start_ff;

   always_comb begin
      base_in = base_ff;
      op_in = op_ff;
      count_in = count_ff;
      pstart_in = pstart_ff;
      ctr_in = ctr_ff;
      end_in = end_ff;
      rd_valid_in = 1'b0;
      rd_addr_in = rd_addr_ff;
      run_in = run_ff;
      res_status_in = res_status_ff;
      res_start_in = res_start_ff;
      ram_we = 1'b0;
      ram_wdata = 1'b0;

      if (csr_we) begin
         base_in = csr_wdata;
      end
      if (cmd.load) begin
         op_in = req_op;
         count_in = req_page_count;
         pstart_in = req_page_start;
      end
      if (cmd.clear) begin
         ram_we = 1'b1;
         ram_wdata = 1'b0;
         ctr_in = ctr_ff + CW'(1);
      end
      if (cmd.scan_init) begin
         ctr_in = base_x[CW-1:0];
         run_in = '0;
      end
      if (cmd.scan) begin
         // reads are issued one ahead of the run count
         if (ctr_ff != TOTAL_C) begin
            rd_valid_in = 1'b1;
            rd_addr_in = ctr_ff[PW-1:0];
            ctr_in = ctr_ff + CW'(1);
         end
         if (rd_valid_ff) begin
            if (ram_rdata) begin
               run_in = '0;
            end else begin
               run_in = run_next[CW-1:0];
            end
         end
      end
      if (cmd.mark_init) begin
         ctr_in = first_x[CW-1:0];
         end_in = rd_addr_ff;
         res_start_in = first_x[PAGE_W-1:0];
         rd_valid_in = 1'b0;
      end
      if (cmd.free_init) begin
         ctr_in = pstart_x[CW-1:0];
         end_in = free_end_x[PW-1:0];
      end
      if (cmd.write) begin
         ram_we = 1'b1;
         ram_wdata = cmd.wdata;
         ctr_in = ctr_ff + CW'(1);
      end
      if (cmd.res_load) begin
         res_status_in = cmd.res_status;
         if (cmd.res_zero_start) begin
            res_start_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= SEARCH_BASE_RESET;
         ctr_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         base_ff <= base_in;
         ctr_ff <= ctr_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      count_ff <= count_in;
      pstart_ff <= pstart_in;
      end_ff <= end_in;
      rd_addr_ff <= rd_addr_in;
      run_ff <= run_in;
      res_status_ff <= res_status_in;
      res_start_ff <= res_start_in;
   end
endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import cpra_pkg::*;

   localparam int PAGE_TOTAL = 1024;
   // slowest request is a scan over the bitmap and a mark of its run, plus stalls and gaps
   localparam int CYCLE_LIMIT = 8_000_000;
   localparam int DRAIN_CYCLES = 2 * PAGE_TOTAL + 64;
   localparam int DIRECTED_ROWS = 23;
   localparam int PHASES = 5;

   typedef struct {
      status_type        status;
      logic [PAGE_W-1:0] start_page;
   } reply_type;

   typedef struct {
      logic       op;
      int         count;
      int         start;
      bit         known;
      status_type status;
      int         start_page;
   } stim_row_type;

   typedef struct {
      int start;
      int count;
   } page_run_type;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [PAGE_W-1:0] csr_wdata;

   cpra_req_if req_bus ();
   cpra_rsp_if rsp_bus ();

   contiguous_page_run_allocator #(
      .TOTAL_PAGE_COUNT(PAGE_TOTAL)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   bit           page_used_map [PAGE_TOTAL];
   int           search_base_cfg;
   reply_type    expected_replies [$];
   page_run_type live_runs [$];
   int           error_count = 0;
   int           cycle_count = 0;
   bit           send_idle_en = 1'b1;
   bit           recv_stall_en = 1'b1;

   // typed expectations only where they follow directly from the state after reset
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_ALLOC,    0,    0, 1'b1, STATUS_INVALID, 0},
      '{OP_ALLOC,  741, 1023, 1'b1, STATUS_INVALID, 0},
      '{OP_ALLOC, 1023,    0, 1'b1, STATUS_INVALID, 0},
      '{OP_ALLOC,  740,    0, 1'b1, STATUS_OK,      284},
      '{OP_ALLOC,    1,    0, 1'b1, STATUS_NOSPACE, 0},
      '{OP_FREE,    25, 1000, 1'b1, STATUS_INVALID, 0},
      '{OP_FREE,     1, 1023, 1'b1, STATUS_OK,      0},
      '{OP_FREE,     0,    0, 1'b1, STATUS_OK,      0},
      '{OP_ALLOC,    1,    0, 1'b1, STATUS_OK,      1023},
      '{OP_FREE,  1023, 1023, 1'b1, STATUS_INVALID, 0},
      '{OP_FREE,  1023,    0, 1'b1, STATUS_OK,      0},
      '{OP_ALLOC,  740,    0, 1'b1, STATUS_NOSPACE, 0},
      '{OP_ALLOC,  739,    0, 1'b1, STATUS_OK,      284},
      '{OP_FREE,    10,  300, 1'b0, STATUS_OK,      0},
      '{OP_ALLOC,    5,    0, 1'b0, STATUS_OK,      0},
      '{OP_ALLOC,    6,    0, 1'b0, STATUS_OK,      0},
      '{OP_ALLOC,    5,    0, 1'b0, STATUS_OK,      0},
      '{OP_FREE,     1,    0, 1'b0, STATUS_OK,      0},
      '{OP_FREE,   512,  512, 1'b1, STATUS_OK,      0},
      '{OP_FREE,     0, 1023, 1'b1, STATUS_OK,      0},
      '{OP_ALLOC,    3,    0, 1'b0, STATUS_OK,      0},
      '{OP_FREE,  1023,    1, 1'b0, STATUS_OK,      0},
      '{OP_ALLOC,    1, 1023, 1'b0, STATUS_OK,      0}
   };

   initial clock = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // first-fit scan and bitmap update for one request word
   function automatic reply_type apply_page_request(logic op, int count, int start);
      reply_type r;
      int        run_len;
      int        p;
      int        q;
      r.status = STATUS_OK;
      r.start_page = '0;
      run_len = 0;
      if (op == OP_ALLOC) begin
         if (count == 0 || search_base_cfg >= PAGE_TOTAL ||
             count > PAGE_TOTAL - search_base_cfg) begin
            r.status = STATUS_INVALID;
            return r;
         end
         for (p = search_base_cfg; p < PAGE_TOTAL; p++) begin
            if (page_used_map[p]) begin
               run_len = 0;
            end else begin
               run_len++;
               if (run_len == count) begin
                  for (q = p + 1 - count; q <= p; q++) page_used_map[q] = 1'b1;
                  r.start_page = PAGE_W'(p + 1 - count);
                  return r;
               end
            end
         end
         r.status = STATUS_NOSPACE;
      end else if (start + count > PAGE_TOTAL) begin
         r.status = STATUS_INVALID;
      end else begin
         for (q = start; q < start + count; q++) page_used_map[q] = 1'b0;
      end
      return r;
   endfunction

   task automatic send_request(logic op, int count, int start, bit known,
                               status_type known_status, int known_start);
      reply_type predicted;
      if (send_idle_en && $urandom_range(99) < 15) begin
         req_bus.valid <= 1'b0;
         req_bus.op <= 1'($urandom_range(1));
         req_bus.page_count <= COUNT_W'($urandom_range(1023));
         req_bus.page_start <= PAGE_W'($urandom_range(1023));
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
      req_bus.valid <= 1'b1;
      req_bus.op <= op;
      req_bus.page_count <= COUNT_W'(count);
      req_bus.page_start <= PAGE_W'(start);
      do @(posedge clock); while (!req_bus.ready);
      predicted = apply_page_request(op, count, start);
      if (op == OP_ALLOC && predicted.status == STATUS_OK)
         live_runs.push_back('{int'(predicted.start_page), count});
      if (known) begin
         predicted.status = known_status;
         predicted.start_page = PAGE_W'(known_start);
      end
      expected_replies.push_back(predicted);
   endtask

   task automatic send_random_request();
      int           pick;
      int           size_pick;
      int           count;
      int           idx;
      page_run_type run;
      pick = $urandom_range(99);
      if (pick < 10) begin
         // noise: any field value at all
         send_request(1'($urandom_range(1)), $urandom_range(1023), $urandom_range(1023),
                      1'b0, STATUS_OK, 0);
      end else if (pick < 55 || live_runs.size() == 0) begin
         size_pick = $urandom_range(99);
         if (size_pick < 70)      count = $urandom_range(8, 1);
         else if (size_pick < 90) count = $urandom_range(64, 9);
         else if (size_pick < 98) count = $urandom_range(256, 65);
         else                     count = $urandom_range(1023, 1);
         send_request(OP_ALLOC, count, $urandom_range(1023), 1'b0, STATUS_OK, 0);
      end else begin
         idx = $urandom_range(live_runs.size() - 1);
         run = live_runs[idx];
         live_runs.delete(idx);
         count = run.count;
         // sometimes free only the head of a run and keep the tail live
         if ($urandom_range(9) == 0 && run.count > 1) begin
            count = $urandom_range(run.count - 1, 1);
            live_runs.push_back('{run.start + count, run.count - count});
         end
         send_request(OP_FREE, count, run.start, 1'b0, STATUS_OK, 0);
      end
   endtask

   task automatic write_search_base(int base);
      req_bus.valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= PAGE_W'(base);
      @(posedge clock);
      csr_we <= 1'b0;
      search_base_cfg = base;
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= !recv_stall_en || ($urandom_range(99) >= 15);
   end

   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected response word, status %0d start_page %0d",
                     $time, rsp_bus.status, rsp_bus.start_page);
            error_count++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_bus.status !== want.status) begin
               $display("%0t: status expected %0d, actual %0d",
                        $time, want.status, rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.start_page !== want.start_page) begin
               $display("%0t: start_page expected %0d, actual %0d",
                        $time, want.start_page, rsp_bus.start_page);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d responses outstanding", $time, expected_replies.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int i;
      int n;
      int phase;
      int phase_base [PHASES];
      int phase_items [PHASES];
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.op <= OP_ALLOC;
      req_bus.page_count <= '0;
      req_bus.page_start <= '0;
      search_base_cfg = SEARCH_BASE_RESET;
      for (i = 0; i < PAGE_TOTAL; i++) page_used_map[i] = 1'b0;
      phase_base = '{0, 1023, $urandom_range(1022, 1), $urandom_range(1022, 1),
                     $urandom_range(1023)};
      phase_items = '{120, 40, 140, 140, 140};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++)
         send_request(directed_rows[i].op, directed_rows[i].count, directed_rows[i].start,
                      directed_rows[i].known, directed_rows[i].status,
                      directed_rows[i].start_page);

      for (phase = 0; phase < PHASES; phase++) begin
         write_search_base(phase_base[phase]);
         // one whole phase without any idling on either side
         send_idle_en = (phase != 2);
         recv_stall_en = (phase != 2);
         for (n = 0; n < phase_items[phase]; n++) send_random_request();
      end

      req_bus.valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### contiguous_page_run_allocator.f
hdl/cpra_pkg.sv
hdl/cpra_req_if.sv
hdl/cpra_rsp_if.sv
hdl/cpra_ram.sv
hdl/cpra_ctrl.sv
hdl/cpra_dp.sv
hdl/contiguous_page_run_allocator.sv
tb/sv/testbench.sv
